// ===== sv/pblr_pkg.sv =====
// ----------------------------------------------------------------------------
// Page buffer lookup and replace: shared package
// Field widths, command codes, page size and the control/status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pblr_pkg;

	localparam int unsigned POS_W  = 32;
	localparam int unsigned LEN_W  = 13;
	localparam int unsigned SLOT_W = 3;

	// Largest number of bytes one buffer holds; longer fills are clipped to it.
	localparam int unsigned PAGE_BYTES = 4 << 10;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_FILL   = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;     // register the incoming item and rewind the scan
		logic issue_rd;    // read the range of the entry under the scan index
		logic age_step;    // compare one entry's age against the oldest so far
		logic take_empty;  // use the first empty entry as the victim
		logic commit;      // update the entries and register the result
	} pblr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_fill;     // captured item is a fill
		logic any_empty;   // at least one entry holds no page
		logic cmp_valid;   // a range read has returned this cycle
		logic cmp_hit;     // the returned range covers the position
		logic cmp_last;    // the returned range belongs to the last entry
		logic age_last;    // the age scan is at the last entry
	} pblr_stat_t;

endpackage

// ===== sv/pblr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Page buffer lookup and replace: controller
// Sequences the range scan of a lookup and the victim search of a fill.
// ----------------------------------------------------------------------------
module pblr_ctrl
	import pblr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  pblr_stat_t stat,
	output pblr_cmd_t  ctl
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_LOOK,
		ST_AGE,
		ST_COMMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.capture = 1'b1;
					state_d     = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (stat.is_fill) begin
					if (stat.any_empty) begin
						ctl.take_empty = 1'b1;
						state_d        = ST_COMMIT;
					end else begin
						state_d = ST_AGE;
					end
				end else begin
					ctl.issue_rd = 1'b1;
					state_d      = ST_LOOK;
				end
			end
			ST_LOOK: begin
				ctl.issue_rd = 1'b1;
				if (stat.cmp_valid && (stat.cmp_hit || stat.cmp_last)) begin
					ctl.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_AGE: begin
				ctl.age_step = 1'b1;
				if (stat.age_last) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				ctl.commit = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != ST_IDLE);
		end
	end

	assign busy = busy_q;

	a_commit_frees: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |=> !busy_q)
		else $error("block still busy after a commit");

	a_accept_busies: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy_q) |=> (busy_q && state_q == ST_DISPATCH))
		else $error("accepted item did not make the block busy");

	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.capture, ctl.take_empty, ctl.age_step}))
		else $error("conflicting commands to the datapath");

endmodule

// ===== sv/pblr_dp.sv =====
// ----------------------------------------------------------------------------
// Page buffer lookup and replace: datapath
// Entry tags, valid bits, age counters, range compare, victim search and
// the result registers.
// ----------------------------------------------------------------------------
module pblr_dp
	import pblr_pkg::*;
#(
	parameter int unsigned ENTRIES  = 8,
	parameter int unsigned AGE_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pblr_cmd_t         ctl,
	output pblr_stat_t        stat,
	input  logic              cmd,
	input  logic [POS_W-1:0]  position,
	input  logic [LEN_W-1:0]  fill_length,
	output logic              done,
	output logic              hit,
	output logic [SLOT_W-1:0] slot,
	output logic              end_of_data,
	output logic              victim_was_valid
);

	localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
	localparam logic [LEN_W-1:0] PAGE_LEN = LEN_W'(PAGE_BYTES);

	// Captured item.
	logic             cmd_q;
	logic [POS_W-1:0] pos_q;
	logic [LEN_W-1:0] len_q;

	// Entry state.
	logic [ENTRIES-1:0]  valid_q;
	logic [AGE_BITS-1:0] age_q [ENTRIES];
	logic [POS_W-1:0]    base_mem [ENTRIES];
	logic [LEN_W-1:0]    len_mem [ENTRIES];
	logic [SLOT_W-1:0]   cur_slot_q;
	logic                cur_present_q;

	// Scan state.
	logic [IDX_W-1:0]    idx_q;
	logic                scan_end_q;
	logic                rd_v_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [POS_W-1:0]    base_s1;
	logic [LEN_W-1:0]    len_s1;
	logic [IDX_W-1:0]    best_idx_q;
	logic [AGE_BITS-1:0] best_age_q;

	// Result registers.
	logic              done_q;
	logic              hit_q;
	logic [SLOT_W-1:0] slot_q;
	logic              eod_q;
	logic              vwv_q;

	logic             rd_fire;
	logic [POS_W:0]   range_end;
	logic             covers;
	logic [IDX_W-1:0] first_empty;
	logic [LEN_W-1:0] len_clip;
	logic             fill_zero;
	logic             commit_lookup;
	logic             commit_fill;

	assign rd_fire = ctl.issue_rd && !scan_end_q;

	// The range end is one bit wider so that it never wraps.
	assign range_end = {1'b0, base_s1} + (POS_W + 1)'(len_s1);
	assign covers    = valid_q[idx_s1] && (base_s1 <= pos_q)
	                   && ({1'b0, pos_q} < range_end);

	always_comb begin
		first_empty = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				first_empty = IDX_W'(i);
			end
		end
	end

	assign len_clip  = (len_q > PAGE_LEN) ? PAGE_LEN : len_q;
	assign fill_zero = (len_q == '0);

	assign commit_lookup = ctl.commit && (cmd_q == CMD_LOOKUP);
	assign commit_fill   = ctl.commit && (cmd_q == CMD_FILL);

	always_comb begin
		stat           = '0;
		stat.is_fill   = (cmd_q == CMD_FILL);
		stat.any_empty = !(&valid_q);
		stat.cmp_valid = rd_v_s1;
		stat.cmp_hit   = covers;
		stat.cmp_last  = (idx_s1 == LAST_IDX);
		stat.age_last  = (idx_q == LAST_IDX);
	end

	// Captured item, scan index and victim tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			scan_end_q <= 1'b0;
			rd_v_s1    <= 1'b0;
		end else begin
			rd_v_s1 <= rd_fire;
			if (ctl.capture) begin
				idx_q      <= '0;
				scan_end_q <= 1'b0;
			end else if (rd_fire || ctl.age_step) begin
				if (idx_q == LAST_IDX) begin
					scan_end_q <= 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q <= cmd;
			pos_q <= position;
			len_q <= fill_length;
		end
		if (rd_fire) begin
			idx_s1 <= idx_q;
		end
		if (ctl.take_empty) begin
			best_idx_q <= first_empty;
		end else if (ctl.age_step) begin
			if ((idx_q == '0) || (age_q[idx_q] > best_age_q)) begin
				best_idx_q <= idx_q;
				best_age_q <= age_q[idx_q];
			end
		end
	end

	// Tag memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (commit_fill && !fill_zero) begin
			base_mem[best_idx_q] <= pos_q;
			len_mem[best_idx_q]  <= len_clip;
		end
		if (rd_fire) begin
			base_s1 <= base_mem[idx_q];
			len_s1  <= len_mem[idx_q];
		end
	end

	// Valid bits, ages and the current entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= '0;
			cur_slot_q    <= '0;
			cur_present_q <= 1'b0;
			for (int i = 0; i < ENTRIES; i++) begin
				age_q[i] <= '0;
			end
		end else begin
			if (commit_lookup) begin
				// Every entry but the one that hit ages, saturating.
				for (int i = 0; i < ENTRIES; i++) begin
					if (!(covers && (idx_s1 == IDX_W'(i))) && (age_q[i] != '1)) begin
						age_q[i] <= age_q[i] + 1'b1;
					end
				end
				if (covers) begin
					cur_slot_q    <= SLOT_W'(idx_s1);
					cur_present_q <= 1'b1;
				end
			end
			if (commit_fill) begin
				if (fill_zero) begin
					valid_q[best_idx_q] <= 1'b0;
				end else begin
					valid_q[best_idx_q] <= 1'b1;
					age_q[best_idx_q]   <= '0;
					cur_slot_q          <= SLOT_W'(best_idx_q);
					cur_present_q       <= 1'b1;
				end
			end
		end
	end

	// Result registers: shown for one cycle after the commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.commit;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_lookup) begin
			hit_q  <= covers;
			slot_q <= covers ? SLOT_W'(idx_s1) : '0;
			eod_q  <= 1'b0;
			vwv_q  <= 1'b0;
		end else if (commit_fill) begin
			hit_q  <= 1'b0;
			slot_q <= SLOT_W'(best_idx_q);
			eod_q  <= fill_zero;
			vwv_q  <= valid_q[best_idx_q];
		end
	end

	assign done             = done_q;
	assign hit              = hit_q;
	assign slot             = slot_q;
	assign end_of_data      = eod_q;
	assign victim_was_valid = vwv_q;

	a_hit_is_current: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && hit_q) |-> (cur_present_q && (cur_slot_q == slot_q)))
		else $error("hit entry was not made current");

	a_fill_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (cmd_q == CMD_FILL)) |-> (valid_q[best_idx_q] == !eod_q))
		else $error("victim valid bit disagrees with the fill result");

	a_commit_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		commit_lookup |-> rd_v_s1)
		else $error("lookup committed without a returned range");

endmodule

// ===== sv/page_buffer_lookup_and_replace_unit.sv =====
// ----------------------------------------------------------------------------
// Page buffer lookup and replace unit
// Tag and aging replacement logic for a small fully associative set of
// page buffers: range lookup with aging, and victim choice on fill.
//
//   Channel  Signals                                   Transfer when
//   -------  ----------------------------------------  --------------------
//   item in  start, busy, cmd, position, fill_length   start && !busy
//   result   done, hit, slot, end_of_data,             done (one cycle)
//            victim_was_valid
//
// A lookup scans from entry 0 and shows its result when the range of the
// first covering entry returns, or after the last entry's range on a miss;
// the scan reads one entry's range per cycle through the tag read port.
// A fill takes the first empty entry when there is one; otherwise the
// age scan visits one entry per cycle to find the oldest.
// busy falls as the result is registered; a new item may be taken in the
// cycle that shows the result. The receiver cannot stall the result.
// Reset empties all entries and clears their ages; no clearing pass is run.
// ----------------------------------------------------------------------------
module page_buffer_lookup_and_replace_unit
	import pblr_pkg::*;
#(
	parameter int unsigned ENTRIES  = 8,
	parameter int unsigned AGE_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              cmd,
	input  logic [POS_W-1:0]  position,
	input  logic [LEN_W-1:0]  fill_length,
	output logic              done,
	output logic              hit,
	output logic [SLOT_W-1:0] slot,
	output logic              end_of_data,
	output logic              victim_was_valid
);

	pblr_cmd_t  ctl;
	pblr_stat_t stat;

	pblr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.ctl    (ctl)
	);

	pblr_dp #(
		.ENTRIES  (ENTRIES),
		.AGE_BITS (AGE_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl              (ctl),
		.stat             (stat),
		.cmd              (cmd),
		.position         (position),
		.fill_length      (fill_length),
		.done             (done),
		.hit              (hit),
		.slot             (slot),
		.end_of_data      (end_of_data),
		.victim_was_valid (victim_was_valid)
	);

endmodule

// ===== verif/page_buffer_lookup_and_replace_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Page buffer lookup and replace unit: testbench
// Sends lookups and fills over the start/busy port, keeps a behavioural copy
// of the entry table to predict every result, and checks each done strobe
// against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module page_buffer_lookup_and_replace_unit_tb;
	import pblr_pkg::*;

	localparam int unsigned ENTRIES     = 8;
	localparam int unsigned AGE_BITS    = 16;
	localparam logic [AGE_BITS-1:0] AGE_MAX = '1;
	localparam int unsigned LATENCY     = ENTRIES + 3;
	localparam int unsigned IDLE_LIMIT  = 2000;
	localparam int unsigned PRINT_LIMIT = 100;
	localparam int unsigned RANDOM_ITEMS = 1350;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              eod;
		logic              evicted;
	} outcome_t;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              start       = 1'b0;
	logic              cmd         = CMD_LOOKUP;
	logic [POS_W-1:0]  position    = '0;
	logic [LEN_W-1:0]  fill_length = '0;
	logic              busy;
	logic              done;
	logic              hit;
	logic [SLOT_W-1:0] slot;
	logic              end_of_data;
	logic              victim_was_valid;

	// Predicted entry table.
	logic                pg_valid [ENTRIES];
	logic [POS_W-1:0]    pg_base  [ENTRIES];
	logic [LEN_W-1:0]    pg_len   [ENTRIES];
	logic [AGE_BITS-1:0] pg_age   [ENTRIES];
	logic [SLOT_W-1:0]   cur_slot;
	logic                cur_present;

	outcome_t    pending_outcomes [$];
	int unsigned error_count  = 0;
	int unsigned burst_left   = 0;
	int unsigned quiet_cycles = 0;
	bit          gaps_on      = 1'b1;

	page_buffer_lookup_and_replace_unit #(
		.ENTRIES (ENTRIES),
		.AGE_BITS(AGE_BITS)
	) uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.cmd             (cmd),
		.position        (position),
		.fill_length     (fill_length),
		.done            (done),
		.hit             (hit),
		.slot            (slot),
		.end_of_data     (end_of_data),
		.victim_was_valid(victim_was_valid)
	);

	always #5 clk = ~clk;

	function automatic logic page_covers(int unsigned i, logic [POS_W-1:0] pos);
		// The range end is formed one bit wider so that it cannot wrap.
		return pg_valid[i] && pg_base[i] <= pos &&
			{1'b0, pos} < {1'b0, pg_base[i]} + 33'(pg_len[i]);
	endfunction

	function automatic int unsigned choose_victim();
		int unsigned pick;
		pick = 0;
		for (int i = 0; i < ENTRIES; i++)
			if (!pg_valid[i])
				return i;
		for (int i = 1; i < ENTRIES; i++)
			if (pg_age[i] > pg_age[pick])
				pick = i;
		return pick;
	endfunction

	function automatic outcome_t predict_outcome(logic c, logic [POS_W-1:0] pos,
			logic [LEN_W-1:0] len);
		outcome_t         o;
		logic             found;
		int unsigned      which;
		logic [LEN_W-1:0] clipped;
		o = '0;
		found = 1'b0;
		which = 0;
		if (c == CMD_LOOKUP) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (!found && page_covers(i, pos)) begin
					found = 1'b1;
					which = i;
				end else if (pg_age[i] != AGE_MAX) begin
					pg_age[i] = pg_age[i] + 1'b1;
				end
			end
			if (found) begin
				cur_slot = which[SLOT_W-1:0];
				cur_present = 1'b1;
			end
			o.hit = found;
		end else begin
			which = choose_victim();
			o.evicted = pg_valid[which];
			clipped = (len > PAGE_BYTES) ? LEN_W'(PAGE_BYTES) : len;
			if (clipped == '0) begin
				pg_valid[which] = 1'b0;
				o.eod = 1'b1;
			end else begin
				pg_valid[which] = 1'b1;
				pg_base[which] = pos;
				pg_len[which] = clipped;
				pg_age[which] = '0;
				cur_slot = which[SLOT_W-1:0];
				cur_present = 1'b1;
			end
		end
		o.slot = which[SLOT_W-1:0];
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		error_count++;
		if (error_count <= PRINT_LIMIT)
			$display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	// Holds the item on the port until it is taken; start is left high so that
	// back-to-back items need no second assignment in the same step.
	task automatic send_item(logic c, logic [POS_W-1:0] pos, logic [LEN_W-1:0] len);
		int unsigned gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(1, 9);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left != 0)
			burst_left--;
		start <= 1'b1;
		cmd <= c;
		position <= pos;
		fill_length <= len;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		pending_outcomes.push_back(predict_outcome(c, pos, len));
	endtask

	task automatic wait_all_results();
		start <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic test_empty_lookups();
		send_item(CMD_LOOKUP, 32'h0000_0000, 13'd0);
		send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 13'h1FFF);
	endtask

	task automatic test_range_edges();
		send_item(CMD_FILL, 32'h0000_1000, 13'd1);
		send_item(CMD_LOOKUP, 32'h0000_1000, 13'd0);
		send_item(CMD_LOOKUP, 32'h0000_1001, 13'd0);
		send_item(CMD_LOOKUP, 32'h0000_0FFF, 13'd0);
		// This range runs past the top of the address space.
		send_item(CMD_FILL, 32'hFFFF_F800, 13'd4096);
		send_item(CMD_LOOKUP, 32'hFFFF_FFFF, 13'd0);
		send_item(CMD_LOOKUP, 32'hFFFF_F7FF, 13'd0);
		// Oversized fills are clipped to a page.
		send_item(CMD_FILL, 32'h0000_2000, 13'h1FFF);
		send_item(CMD_LOOKUP, 32'h0000_2FFF, 13'd0);
		send_item(CMD_LOOKUP, 32'h0000_3000, 13'd0);
		send_item(CMD_FILL, 32'h0000_4000, 13'd4097);
		send_item(CMD_LOOKUP, 32'h0000_5000, 13'd0);
		send_item(CMD_LOOKUP, 32'h0000_4FFF, 13'd0);
	endtask

	task automatic test_first_match_wins();
		send_item(CMD_FILL, 32'h0000_1000, 13'd4096);
		send_item(CMD_LOOKUP, 32'h0000_1000, 13'd0);
		send_item(CMD_LOOKUP, 32'h0000_1800, 13'd0);
	endtask

	task automatic test_end_of_data();
		int unsigned victim;
		send_item(CMD_FILL, 32'h0000_9000, 13'd0);
		send_item(CMD_FILL, 32'h0000_6000, 13'd4096);
		send_item(CMD_FILL, 32'h0000_7000, 13'd16);
		send_item(CMD_FILL, 32'h0000_8000, 13'd4096);
		send_item(CMD_FILL, 32'h0000_A000, 13'd4096);
		// All entries now hold pages, so this one empties the oldest.
		victim = choose_victim();
		send_item(CMD_FILL, 32'h0000_0000, 13'd0);
		send_item(CMD_LOOKUP, pg_base[victim], 13'd0);
		send_item(CMD_FILL, 32'hFFFF_FFFF, 13'd1);
	endtask

	// One entry is kept hot while all the others age, so the following fills
	// must evict the stale entries in order of age and never the hot one.
	task automatic test_aging();
		logic [POS_W-1:0] hot;
		hot = 32'h8000_0000;
		gaps_on = 1'b0;
		send_item(CMD_FILL, hot, 13'd4096);
		for (int i = 0; i < ENTRIES; i++)
			if (!pg_valid[i])
				send_item(CMD_FILL, hot + 32'h0001_0000 * (i + 1), 13'd64);
		repeat (100) send_item(CMD_LOOKUP, hot, 13'd0);
		send_item(CMD_FILL, hot + 32'h0010_0000, 13'd64);
		repeat (40) send_item(CMD_LOOKUP, hot, 13'd0);
		send_item(CMD_FILL, hot + 32'h0020_0000, 13'd64);
		wait_all_results();
		gaps_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		logic             c;
		logic [POS_W-1:0] pos;
		logic [LEN_W-1:0] len;
		int unsigned      e;
		int unsigned      roll;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 250 == 0) begin
				if (n != 0)
					wait_all_results();
				gaps_on = ($urandom_range(0, 3) != 0);
			end
			e = $urandom_range(0, ENTRIES - 1);
			roll = $urandom_range(0, 99);
			if (roll < 55) begin
				// Lookups aim mostly inside or just beside a held range.
				c = CMD_LOOKUP;
				len = LEN_W'($urandom());
				roll = $urandom_range(0, 99);
				if (!pg_valid[e] || roll >= 92)
					pos = $urandom();
				else if (roll >= 85)
					pos = $urandom_range(0, 32'h0001_FFFF);
				else if (roll < 65)
					pos = pg_base[e] + $urandom_range(0, pg_len[e] - 1);
				else if (roll < 70)
					pos = pg_base[e];
				else if (roll < 78)
					pos = pg_base[e] + pg_len[e];
				else
					pos = pg_base[e] - 1;
			end else begin
				c = CMD_FILL;
				roll = $urandom_range(0, 99);
				if (roll < 45)
					pos = $urandom_range(0, 32'h0001_FFFF);
				else if (roll < 60)
					pos = 32'hFFFF_0000 | $urandom_range(0, 32'h0000_FFFF);
				else if (roll < 80 && pg_valid[e])
					pos = pg_base[e] + $urandom_range(0, 8191) - 4096;
				else
					pos = $urandom();
				roll = $urandom_range(0, 99);
				if (roll < 10)
					len = '0;
				else if (roll < 20)
					len = LEN_W'($urandom_range(4097, 8191));
				else if (roll < 25)
					len = 13'd4096;
				else if (roll < 45)
					len = LEN_W'($urandom_range(1, 64));
				else
					len = LEN_W'($urandom_range(1, 4096));
			end
			send_item(c, pos, len);
		end
	endtask

	always @(posedge clk) begin : check_results
		outcome_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch("unexpected result transfer", {31'd0, done}, 32'd0);
			end else begin
				want = pending_outcomes.pop_front();
				if (hit !== want.hit)
					report_mismatch("hit", 32'(hit), 32'(want.hit));
				if (slot !== want.slot)
					report_mismatch("slot", 32'(slot), 32'(want.slot));
				if (end_of_data !== want.eod)
					report_mismatch("end_of_data", 32'(end_of_data), 32'(want.eod));
				if (victim_was_valid !== want.evicted)
					report_mismatch("victim_was_valid", 32'(victim_was_valid),
						32'(want.evicted));
			end
		end
	end

	// Ends a run that has stopped moving in either direction.
	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("page_buffer_lookup_and_replace_unit test failed");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			pg_valid[i] = 1'b0;
			pg_base[i] = '0;
			pg_len[i] = '0;
			pg_age[i] = '0;
		end
		cur_slot = '0;
		cur_present = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_lookups();
		test_range_edges();
		test_first_match_wins();
		test_end_of_data();
		wait_all_results();
		test_aging();
		test_random_traffic();
		wait_all_results();
		if (error_count == 0)
			$display("page_buffer_lookup_and_replace_unit test passed");
		else
			$display("page_buffer_lookup_and_replace_unit test failed");
		$finish;
	end

endmodule

// ===== files.f =====
sv/pblr_pkg.sv
sv/pblr_ctrl.sv
sv/pblr_dp.sv
sv/page_buffer_lookup_and_replace_unit.sv
verif/page_buffer_lookup_and_replace_unit_tb.sv
